/* rtl/core/segment_sequence_controller_assert.svh */
// ----------------------------------------------------------------------------
// Segment sequence controller assertion macros
// Implication and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEQUENCE_CONTROLLER_ASSERT_SVH
`define SEGMENT_SEQUENCE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define SSC_ASSERT_IMP(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error("ssc: assertion failed");

// next-cycle implication
`define SSC_ASSERT_NXT(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error("ssc: assertion failed");

`endif

/* rtl/core/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Types, codes and stream payload layouts of the segment sequence controller.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int SSC_MAX_SEGMENTS = 64;
    localparam int SSC_CFG_W        = 32;
    localparam int SSC_CFG_AW       = 1;
    localparam int SSC_MODE_W       = 2;
    localparam int SSC_IN_W         = 80;
    localparam int SSC_OUT_W        = 152;
    localparam int SSC_CNT_NUM      = 6;

    localparam logic [1:0] GRADE_UNSUPPORTED = 2'd3;

    typedef enum logic [SSC_CFG_AW-1:0] {
        CFG_AVAILABLE_CAPS = 1'd0,
        CFG_SEG_COUNT      = 1'd1
    } cfg_reg_t;

    typedef enum logic [SSC_MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        POL_TIMED       = 3'd0,
        POL_TIMED_INPUT = 3'd1,
        POL_INPUT       = 3'd2,
        POL_RESOURCE    = 3'd3,
        POL_SOURCE      = 3'd4,
        POL_UNSUPPORTED = 3'd5
    } policy_t;

    typedef enum logic [2:0] {
        CAUSE_NONE        = 3'd0,
        CAUSE_TIMEOUT     = 3'd1,
        CAUSE_INPUT       = 3'd2,
        CAUSE_RESOURCE    = 3'd3,
        CAUSE_SOURCE      = 3'd4,
        CAUSE_COMPLETE    = 3'd5,
        CAUSE_UNSUPPORTED = 3'd6
    } cause_t;

    // counter slots; slots 1..4 line up with the cause codes
    localparam logic [2:0] CNT_ALL   = 3'd0;
    localparam logic [2:0] CNT_UNSUP = 3'd5;

    typedef struct packed {
        policy_t     policy;
        logic [1:0]  completeness;
        logic [31:0] caps;
        logic [15:0] duration;
        logic [7:0]  segment;
    } seg_entry_t;

    // listed from the highest bit down
    typedef struct packed {
        logic [5:0]  pad;
        logic [2:0]  counter_select;
        logic        source_done;
        logic        res_ready;
        logic        start_button;
        logic        confirm;
        logic [7:0]  entry_segment;
        logic [15:0] entry_duration;
        logic [31:0] entry_caps;
        logic [1:0]  entry_completeness;
        logic [2:0]  entry_policy;
        logic [5:0]  entry_index;
    } ssc_in_t;

    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] counter_value;
        logic [31:0] frame_in_segment;
        logic [31:0] frame_total;
        logic [2:0]  last_cause;
        logic [31:0] missing_caps;
        logic [1:0]  grade;
        logic [7:0]  segment_id;
        logic        stalled;
        logic        done_res;
        logic        running;
        logic        ok;
    } ssc_out_t;

endpackage

/* rtl/core/ssc_table.sv */
// ----------------------------------------------------------------------------
// ssc_table
// Segment table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssc_table
    import ssc_pkg::*;
#(
    parameter int DEPTH = SSC_MAX_SEGMENTS,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  seg_entry_t    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output seg_entry_t    rd_data
);

    seg_entry_t tbl_mem [DEPTH];
    seg_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= tbl_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/segment_sequence_controller.sv */
// ----------------------------------------------------------------------------
// segment_sequence_controller
// Table-driven segment sequencer with per-cause transition counters.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr_en/cfg_addr/cfg_wdata write available_caps (0) and the segment
//   count (1); write only while the block is idle.
//   s_* carries one item per transaction; s_tuser holds the mode (load
//   entry, start, frame tick or no-op). Every item yields exactly one m_*
//   transaction that reports the status after the item.
//   Timing: the item's table read issues at the accept edge, the update runs
//   once the output register can take its result, and the result is
//   registered there and shows on m_tvalid. A new item is taken only after
//   the update has run, because of the registered read of the segment table.
//   A finished result waits in the output register; one further item can be
//   accepted meanwhile and holds in the update stage until the register
//   frees. Reset clears all run state and both configuration registers; the
//   segment table keeps no reset and must be loaded before it is used.
// ----------------------------------------------------------------------------
module segment_sequence_controller
    import ssc_pkg::*;
#(
    parameter int MAX_SEGMENTS = SSC_MAX_SEGMENTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [SSC_CFG_AW-1:0] cfg_addr,
    input  logic [SSC_CFG_W-1:0]  cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // entry_index, entry_policy, entry_completeness, entry_caps,
    // entry_duration, entry_segment, confirm, start_button,
    // res_ready, source_done, counter_select, zero pad
    input  logic [SSC_IN_W-1:0]   s_tdata,
    // mode
    input  logic [SSC_MODE_W-1:0] s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // ok, running, done_res, stalled, segment_id, grade, missing_caps,
    // last_cause, frame_total, frame_in_segment, counter_value, zero pad
    output logic [SSC_OUT_W-1:0]  m_tdata
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = ((AW > 7) ? AW : 7) + 1;

    // configuration
    logic [31:0]   avail_caps_reg;
    logic [6:0]    seg_count_reg;

    // update stage
    logic          busy_reg;
    ssc_in_t       item_reg;
    mode_t         mode_reg;
    logic          exec;
    logic          accept;

    // run state
    logic [AW-1:0] cur_idx_reg,  cur_idx_next;
    seg_entry_t    entry_reg,    entry_next;
    logic [31:0]   missing_reg,  missing_next;
    cause_t        cause_reg,    cause_next;
    logic          running_reg,  running_next;
    logic          finished_reg, finished_next;
    logic          stalled_reg,  stalled_next;
    logic [31:0]   ft_reg,       ft_next;
    logic [31:0]   fis_reg,      fis_next;
    logic [31:0]   cnt_reg  [SSC_CNT_NUM];
    logic [31:0]   cnt_next [SSC_CNT_NUM];

    // output register
    logic          out_valid_reg;
    ssc_out_t      out_reg, out_next;

    // table port
    logic          tbl_wr_en;
    logic [AW-1:0] tbl_rd_addr;
    seg_entry_t    tbl_wr_data;
    seg_entry_t    tbl_rd_data;

    ssc_in_t       s_item;
    logic [CW-1:0] eff_count;
    logic          idx_ok;
    logic          step_go;
    cause_t        step_cause;
    logic          do_enter;
    logic [AW-1:0] enter_idx;
    logic          ok;
    logic [31:0]   fis_inc;
    logic          timeout;
    logic          pressed;
    logic          last_entry;
    logic [31:0]   cnt_sel;

    assign s_item   = ssc_in_t'(s_tdata);
    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    // one item in flight at a time: the next table read never meets this
    // item's table write
    assign exec     = busy_reg && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = SSC_OUT_W'(out_reg);

    assign eff_count = (CW'(seg_count_reg) > CW'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS)
                                                                : CW'(seg_count_reg);
    assign idx_ok    = CW'(item_reg.entry_index) < CW'(MAX_SEGMENTS);

    always_comb
    begin
        tbl_wr_data.policy       = (item_reg.entry_policy > 3'(POL_UNSUPPORTED))
                                   ? POL_UNSUPPORTED : policy_t'(item_reg.entry_policy);
        tbl_wr_data.completeness = item_reg.entry_completeness;
        tbl_wr_data.caps         = item_reg.entry_caps;
        tbl_wr_data.duration     = item_reg.entry_duration;
        tbl_wr_data.segment      = item_reg.entry_segment;
    end

    assign tbl_wr_en   = exec && (mode_reg == MODE_LOAD) && idx_ok;
    assign tbl_rd_addr = (mode_t'(s_tuser) == MODE_START) ? '0 : cur_idx_reg + 1'b1;

    ssc_table #(
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (AW'(item_reg.entry_index)),
        .wr_data (tbl_wr_data),
        .rd_en   (accept),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_caps_reg <= '0;
            seg_count_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_AVAILABLE_CAPS: avail_caps_reg <= cfg_wdata;
                CFG_SEG_COUNT:      seg_count_reg  <= cfg_wdata[6:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= s_item;
            mode_reg <= mode_t'(s_tuser);
        end
    end

    assign pressed    = item_reg.confirm || item_reg.start_button;
    assign fis_inc    = fis_reg + 32'd1;
    assign timeout    = fis_inc >= 32'(entry_reg.duration);
    assign last_entry = (CW'(cur_idx_reg) + CW'(1)) >= eff_count;

    always_comb
    begin
        step_go    = 1'b0;
        step_cause = CAUSE_NONE;
        unique case (entry_reg.policy)
            POL_TIMED:
            begin
                step_go    = timeout;
                step_cause = CAUSE_TIMEOUT;
            end
            POL_TIMED_INPUT:
            begin
                step_go    = pressed || timeout;
                step_cause = pressed ? CAUSE_INPUT : CAUSE_TIMEOUT;
            end
            POL_INPUT:
            begin
                step_go    = pressed;
                step_cause = CAUSE_INPUT;
            end
            POL_RESOURCE:
            begin
                step_go    = item_reg.res_ready;
                step_cause = CAUSE_RESOURCE;
            end
            POL_SOURCE:
            begin
                step_go    = item_reg.source_done;
                step_cause = CAUSE_SOURCE;
            end
            default:
            begin
                step_go    = 1'b0;
                step_cause = CAUSE_NONE;
            end
        endcase
    end

    always_comb
    begin
        cur_idx_next  = cur_idx_reg;
        entry_next    = entry_reg;
        missing_next  = missing_reg;
        cause_next    = cause_reg;
        running_next  = running_reg;
        finished_next = finished_reg;
        stalled_next  = stalled_reg;
        ft_next       = ft_reg;
        fis_next      = fis_reg;
        for (int i = 0; i < SSC_CNT_NUM; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        ok        = 1'b0;
        do_enter  = 1'b0;
        enter_idx = '0;

        unique case (mode_reg)
            MODE_LOAD:
            begin
                ok = idx_ok;
            end
            MODE_START:
            begin
                cur_idx_next  = '0;
                entry_next    = '0;
                missing_next  = '0;
                cause_next    = CAUSE_NONE;
                running_next  = 1'b0;
                finished_next = 1'b0;
                stalled_next  = 1'b0;
                ft_next       = '0;
                fis_next      = '0;
                for (int i = 0; i < SSC_CNT_NUM; i++)
                begin
                    cnt_next[i] = '0;
                end
                if (eff_count != '0)
                begin
                    do_enter     = 1'b1;
                    running_next = 1'b1;
                    ok           = 1'b1;
                end
            end
            MODE_TICK:
            begin
                if (running_reg && !finished_reg)
                begin
                    ok       = 1'b1;
                    ft_next  = ft_reg + 32'd1;
                    fis_next = fis_inc;
                    if (!stalled_reg && (missing_reg == '0) && step_go)
                    begin
                        cause_next = step_cause;
                        cnt_next[CNT_ALL] = cnt_reg[CNT_ALL] + 32'd1;
                        cnt_next[3'(step_cause)] = cnt_reg[3'(step_cause)] + 32'd1;
                        if (last_entry)
                        begin
                            finished_next = 1'b1;
                            cause_next    = CAUSE_COMPLETE;
                        end
                        else
                        begin
                            do_enter  = 1'b1;
                            enter_idx = cur_idx_reg + 1'b1;
                        end
                    end
                end
            end
            MODE_NOP:
            begin
                ok = 1'b0;
            end
        endcase

        if (do_enter)
        begin
            entry_next   = tbl_rd_data;
            cur_idx_next = enter_idx;
            fis_next     = '0;
            missing_next = tbl_rd_data.caps & ~avail_caps_reg;
            stalled_next = (tbl_rd_data.policy >= POL_UNSUPPORTED)
                           || (tbl_rd_data.completeness == GRADE_UNSUPPORTED)
                           || (missing_next != '0);
            if (tbl_rd_data.policy >= POL_UNSUPPORTED)
            begin
                cause_next          = CAUSE_UNSUPPORTED;
                cnt_next[CNT_UNSUP] = cnt_next[CNT_UNSUP] + 32'd1;
            end
        end
    end

    always_comb
    begin
        if (item_reg.counter_select < 3'(SSC_CNT_NUM))
        begin
            cnt_sel = cnt_next[item_reg.counter_select];
        end
        else
        begin
            cnt_sel = '0;
        end
        out_next                  = '0;
        out_next.ok               = ok;
        out_next.running          = running_next;
        out_next.done_res         = finished_next;
        out_next.stalled          = stalled_next;
        out_next.segment_id       = entry_next.segment;
        out_next.grade            = entry_next.completeness;
        out_next.missing_caps     = missing_next;
        out_next.last_cause       = cause_next;
        out_next.frame_total      = ft_next;
        out_next.frame_in_segment = fis_next;
        out_next.counter_value    = cnt_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
            entry_reg     <= '0;
            missing_reg   <= '0;
            cause_reg     <= CAUSE_NONE;
            running_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            stalled_reg   <= 1'b0;
            ft_reg        <= '0;
            fis_reg       <= '0;
            for (int i = 0; i < SSC_CNT_NUM; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (exec)
            begin
                busy_reg <= 1'b0;
            end

            if (exec)
            begin
                out_valid_reg <= 1'b1;
                cur_idx_reg   <= cur_idx_next;
                entry_reg     <= entry_next;
                missing_reg   <= missing_next;
                cause_reg     <= cause_next;
                running_reg   <= running_next;
                finished_reg  <= finished_next;
                stalled_reg   <= stalled_next;
                ft_reg        <= ft_next;
                fis_reg       <= fis_next;
                for (int i = 0; i < SSC_CNT_NUM; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_reg <= out_next;
        end
    end

endmodule

/* rtl/core/ssc_checker.sv */
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks of the segment sequence controller, bound to the top.
// ----------------------------------------------------------------------------
`include "segment_sequence_controller_assert.svh"

module ssc_checker
    import ssc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [SSC_OUT_W-1:0] m_tdata
);

    ssc_out_t mon;
    logic     flags_in_run;
    logic     idle_clear;

    assign mon = ssc_out_t'(m_tdata);

    // finished and blocked only exist inside a run
    assign flags_in_run = mon.running || !(mon.done_res || mon.stalled);

    // outside a run the frame counts and the selected counter sit at zero and no cause is set
    assign idle_clear = mon.running ||
                        ((mon.frame_total == '0) && (mon.frame_in_segment == '0) &&
                         (mon.counter_value == '0) && (mon.last_cause == CAUSE_NONE));

    // items are spaced by the table read: no accept in the next cycle
    `SSC_ASSERT_NXT(a_accept_spacing, clk, rst_n, s_tvalid && s_tready, !s_tready)

    `SSC_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    `SSC_ASSERT_IMP(a_flags_need_run, clk, rst_n, m_tvalid, flags_in_run)

    `SSC_ASSERT_IMP(a_idle_counts, clk, rst_n, m_tvalid, idle_clear)

endmodule

bind segment_sequence_controller ssc_checker u_ssc_checker (.*);
